// ----- hdl/ps2sc_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 scancode set 1 decoder package
// Shared constants, prefix state type and result record for the decoder.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

  localparam logic [7:0] SC_E0               = 8'hE0;
  localparam logic [7:0] SC_E1               = 8'hE1;
  localparam logic [7:0] SC_FAKE_SHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_FAKE_SHIFT_BREAK = 8'hAA;

  localparam logic [6:0] K_LSHIFT  = 7'h2A;
  localparam logic [6:0] K_RSHIFT  = 7'h36;
  localparam logic [6:0] K_LCTRL   = 7'h1D;
  localparam logic [6:0] K_LALT    = 7'h38;
  localparam logic [6:0] K_CAPS    = 7'h3A;
  localparam logic [6:0] K_NUM     = 7'h45;
  localparam logic [6:0] K_DEL_EXT = 7'h53;

  typedef enum logic [3:0] {
    PFX_IDLE      = 4'b0001,
    PFX_AFTER_E0  = 4'b0010,
    PFX_E1_FIRST  = 4'b0100,
    PFX_E1_SECOND = 4'b1000
  } pfx_t;

  typedef struct packed {
    logic       event_valid;
    logic       extended;
    logic [6:0] key_index;
    logic       pressed;
    logic       caps_lock;
    logic       num_lock;
    logic       shift_held;
    logic [2:0] led_bits;
    logic       led_change;
    logic       reboot_request;
  } res_t;

endpackage

// ----- hdl/ps2sc_if.sv -----
// ----------------------------------------------------------------------------
// PS/2 scancode decoder channels
// Valid/ready channels for incoming scancode bytes and decoded key events.
// ----------------------------------------------------------------------------
interface ps2sc_scan_if;
  logic       valid;
  logic       ready;
  logic [7:0] scancode;

  modport source (output valid, output scancode, input ready);
  modport sink (input valid, input scancode, output ready);
  modport monitor (input valid, input scancode, input ready);
endinterface

interface ps2sc_evt_if;
  logic       valid;
  logic       ready;
  logic       event_valid;
  logic       extended;
  logic [6:0] key_index;
  logic       pressed;
  logic       caps_lock;
  logic       num_lock;
  logic       shift_held;
  logic [2:0] led_bits;
  logic       led_change;
  logic       reboot_request;

  modport source (
    output valid, output event_valid, output extended, output key_index,
    output pressed, output caps_lock, output num_lock, output shift_held,
    output led_bits, output led_change, output reboot_request, input ready
  );
  modport sink (
    input valid, input event_valid, input extended, input key_index,
    input pressed, input caps_lock, input num_lock, input shift_held,
    input led_bits, input led_change, input reboot_request, output ready
  );
  modport monitor (
    input valid, input event_valid, input extended, input key_index,
    input pressed, input caps_lock, input num_lock, input shift_held,
    input led_bits, input led_change, input reboot_request, input ready
  );
endinterface

// ----- hdl/ps2sc_decode.sv -----
// ----------------------------------------------------------------------------
// PS/2 scancode decode core
// Prefix state machine, lock and modifier key state, and per-byte result.
// ----------------------------------------------------------------------------
module ps2sc_decode (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  logic [7:0]        scancode,
  output ps2sc_pkg::res_t   res
);
  import ps2sc_pkg::*;

  // Only the modifier keys that feed an output are kept from the key map.
  pfx_t pfx, pfx_next;
  logic caps, caps_next;
  logic num, num_next;
  logic lctrl, lctrl_next;
  logic lalt, lalt_next;
  logic lshift, lshift_next;
  logic rshift, rshift_next;

  logic       have_key;
  logic       ext;
  logic       std_key;
  logic [6:0] code;
  logic       prs;
  logic       fwd;
  logic       ledch;
  logic       reboot;

  always_comb begin
    pfx_next = PFX_IDLE;
    have_key = 1'b0;
    ext      = 1'b0;
    unique case (pfx)
      PFX_E1_SECOND: begin
        pfx_next = PFX_IDLE;
      end
      PFX_E1_FIRST: begin
        pfx_next = PFX_E1_SECOND;
      end
      PFX_AFTER_E0: begin
        pfx_next = PFX_IDLE;
        if (scancode != SC_FAKE_SHIFT_MAKE && scancode != SC_FAKE_SHIFT_BREAK) begin
          have_key = 1'b1;
          ext      = 1'b1;
        end
      end
      default: begin
        if (scancode == SC_E0) begin
          pfx_next = PFX_AFTER_E0;
        end else if (scancode == SC_E1) begin
          pfx_next = PFX_E1_FIRST;
        end else begin
          have_key = 1'b1;
        end
      end
    endcase

    code    = have_key ? scancode[6:0] : 7'd0;
    prs     = have_key & ~scancode[7];
    std_key = have_key & ~ext;

    lctrl_next  = (std_key && code == K_LCTRL)  ? prs : lctrl;
    lalt_next   = (std_key && code == K_LALT)   ? prs : lalt;
    lshift_next = (std_key && code == K_LSHIFT) ? prs : lshift;
    rshift_next = (std_key && code == K_RSHIFT) ? prs : rshift;

    caps_next = caps;
    num_next  = num;
    fwd       = 1'b0;
    ledch     = 1'b0;
    reboot    = 1'b0;
    if (have_key) begin
      if (ext && code == K_DEL_EXT) begin
        fwd    = 1'b1;
        reboot = lctrl_next & lalt_next;
      end else if (!ext && code == K_NUM) begin
        num_next = num ^ prs;
        ledch    = prs;
      end else if (!ext && code == K_CAPS) begin
        caps_next = caps ^ prs;
        ledch     = prs;
      end else begin
        fwd = 1'b1;
      end
    end

    res.event_valid    = fwd;
    res.extended       = ext;
    res.key_index      = code;
    res.pressed        = prs;
    res.caps_lock      = caps_next;
    res.num_lock       = num_next;
    res.shift_held     = lshift_next | rshift_next;
    res.led_bits       = {caps_next, num_next, 1'b0};
    res.led_change     = ledch;
    res.reboot_request = reboot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pfx    <= PFX_IDLE;
      caps   <= 1'b0;
      num    <= 1'b0;
      lctrl  <= 1'b0;
      lalt   <= 1'b0;
      lshift <= 1'b0;
      rshift <= 1'b0;
    end else if (fire) begin
      pfx    <= pfx_next;
      caps   <= caps_next;
      num    <= num_next;
      lctrl  <= lctrl_next;
      lalt   <= lalt_next;
      lshift <= lshift_next;
      rshift <= rshift_next;
    end
  end

endmodule

// ----- hdl/ps2_scancode_set1_decoder.sv -----
// ----------------------------------------------------------------------------
// PS/2 scancode set 1 decoder
// Decodes set-1 bytes into key events with lock, shift and reboot status.
// ----------------------------------------------------------------------------
//   channel  dir  payload
//   scan     in   scancode[7:0]
//   evt      out  event_valid, extended, key_index[6:0], pressed, caps_lock,
//                 num_lock, shift_held, led_bits[2:0], led_change,
//                 reboot_request
//
// One byte is accepted every cycle while scan.ready is high; each gives one item,
// through an input register and a result register.
// Synchronous reset clears the prefix machine, locks and modifier keys.
// A stalled output holds its item while one more byte waits in the input
// register; scan.ready drops only when both registers are full.
module ps2_scancode_set1_decoder (
  input  logic clk,
  input  logic rst,
  ps2sc_scan_if.sink  scan,
  ps2sc_evt_if.source evt
);
  import ps2sc_pkg::*;

  logic       in_valid;
  logic [7:0] in_code;
  logic       out_valid;
  res_t       out_res;
  res_t       res;
  logic       advance;

  assign advance    = !out_valid || evt.ready;
  assign scan.ready = !in_valid || advance;

  ps2sc_decode u_decode (
    .clk      (clk),
    .rst      (rst),
    .fire     (in_valid && advance),
    .scancode (in_code),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (scan.ready) begin
        in_valid <= scan.valid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan.valid && scan.ready) begin
      in_code <= scan.scancode;
    end
    if (in_valid && advance) begin
      out_res <= res;
    end
  end

  assign evt.valid          = out_valid;
  assign evt.event_valid    = out_res.event_valid;
  assign evt.extended       = out_res.extended;
  assign evt.key_index      = out_res.key_index;
  assign evt.pressed        = out_res.pressed;
  assign evt.caps_lock      = out_res.caps_lock;
  assign evt.num_lock       = out_res.num_lock;
  assign evt.shift_held     = out_res.shift_held;
  assign evt.led_bits       = out_res.led_bits;
  assign evt.led_change     = out_res.led_change;
  assign evt.reboot_request = out_res.reboot_request;

endmodule

// ----- hdl/ps2sc_checker.sv -----
// ----------------------------------------------------------------------------
// PS/2 scancode decoder checker
// Port-level properties of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ps2sc_checker (
  input logic       clk,
  input logic       rst,
  input logic       scan_ready,
  input logic       evt_valid,
  input logic       evt_ready,
  input logic       event_valid,
  input logic       extended,
  input logic [6:0] key_index,
  input logic       pressed,
  input logic       caps_lock,
  input logic       num_lock,
  input logic [2:0] led_bits,
  input logic       led_change,
  input logic       reboot_request
);
  import ps2sc_pkg::*;

  a_led_match: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> (led_bits[2] == caps_lock && led_bits[1] == num_lock
                   && led_bits[0] == 1'b0))
    else $error("LED bits disagree with lock state");

  a_reboot_del: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && reboot_request) |->
      (event_valid && extended && key_index == K_DEL_EXT))
    else $error("Reboot request without extended Del");

  a_led_change_lock: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && led_change) |->
      (!event_valid && !extended && pressed
       && (key_index == K_CAPS || key_index == K_NUM)))
    else $error("LED change without a lock key press");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (evt_valid && !evt_ready) |=> (evt_valid && $stable(key_index)
                                   && $stable(caps_lock) && $stable(num_lock)))
    else $error("Stalled item changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!evt_valid && scan_ready))
    else $error("Decoder not empty right after reset");

endmodule

bind ps2_scancode_set1_decoder ps2sc_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .scan_ready     (scan.ready),
  .evt_valid      (evt.valid),
  .evt_ready      (evt.ready),
  .event_valid    (evt.event_valid),
  .extended       (evt.extended),
  .key_index      (evt.key_index),
  .pressed        (evt.pressed),
  .caps_lock      (evt.caps_lock),
  .num_lock       (evt.num_lock),
  .led_bits       (evt.led_bits),
  .led_change     (evt.led_change),
  .reboot_request (evt.reboot_request)
);
